[rtl/rehb_pkg.sv]
// Package for the Raft election and heartbeat controller.
// Holds codes, widths, command and configuration types and small helper functions.
// Depends on nothing; every other file of the block but rehb_ram uses it.
package rehb_pkg;

    localparam int MAX_NODES = 8;
    localparam int PEER_W    = $clog2(MAX_NODES);
    localparam int NODE_W    = 4;
    localparam int LOG_DEPTH = 1024;
    localparam int LOG_AW    = $clog2(LOG_DEPTH);
    localparam int IDX_W     = 11;
    localparam int TERM_W    = 32;
    localparam int CD_W      = 17;
    localparam int LFSR_W    = 16;
    localparam int CFG_AW    = 5;

    localparam logic [TERM_W-1:0] TERM_MAX   = '1;
    localparam logic [LFSR_W-1:0] LFSR_SEED  = 16'hACE1;
    localparam logic [15:0]       HB_SAT     = 16'hFFFF;
    localparam logic [3:0]        VOTES_SAT  = 4'hF;

    localparam logic [1:0] MODE_TICK   = 2'd0;
    localparam logic [1:0] MODE_VOTE   = 2'd1;
    localparam logic [1:0] MODE_APPEND = 2'd2;
    localparam logic [1:0] MODE_CLIENT = 2'd3;

    localparam logic [1:0] KIND_VREQ   = 2'd0;
    localparam logic [1:0] KIND_HBEAT  = 2'd1;
    localparam logic [1:0] KIND_STATUS = 2'd2;

    localparam logic [1:0] ROLE_FOLLOWER  = 2'd0;
    localparam logic [1:0] ROLE_CANDIDATE = 2'd1;
    localparam logic [1:0] ROLE_LEADER    = 2'd2;

    localparam logic [1:0] STAT_OK         = 2'd0;
    localparam logic [1:0] STAT_NOT_LEADER = 2'd1;
    localparam logic [1:0] STAT_FULL       = 2'd2;

    localparam logic [2:0] REG_CLUSTER = 3'd0;
    localparam logic [2:0] REG_SELF    = 3'd1;
    localparam logic [2:0] REG_HB      = 3'd2;
    localparam logic [2:0] REG_EMIN    = 3'd3;
    localparam logic [2:0] REG_ESPAN   = 3'd4;

    localparam logic [3:0]  RST_CLUSTER = 4'd1;
    localparam logic [2:0]  RST_SELF    = 3'd0;
    localparam logic [15:0] RST_HB      = 16'd50;
    localparam logic [15:0] RST_EMIN    = 16'd150;
    localparam logic [15:0] RST_ESPAN   = 16'd150;

    typedef enum logic [1:0] {
        OP_TICK,
        OP_VOTE,
        OP_APPEND,
        OP_CLIENT
    } t_op;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PEER,
        ST_EMIT
    } t_state;

    typedef struct packed {
        t_op                op;
        logic [PEER_W-1:0]  peer;
        logic               peer_ok;
        logic [TERM_W-1:0]  reply_term;
        logic               granted;
    } t_cmd;

    typedef struct packed {
        logic [NODE_W-1:0] cluster;
        logic [PEER_W-1:0] self_idx;
        logic [15:0]       hb_interval;
        logic [15:0]       elec_min;
        logic [15:0]       elec_span;
    } t_cfg;

    function automatic logic [NODE_W-1:0] node_count(input logic [NODE_W-1:0] c);
        logic [NODE_W-1:0] r;
        if (c == '0) begin
            r = NODE_W'(1);
        end else if (c > NODE_W'(MAX_NODES)) begin
            r = NODE_W'(MAX_NODES);
        end else begin
            r = c;
        end
        return r;
    endfunction

    function automatic logic [LFSR_W-1:0] lfsr_step(input logic [LFSR_W-1:0] s);
        logic fb;
        fb = s[0] ^ s[2] ^ s[3] ^ s[5];
        return {fb, s[LFSR_W-1:1]};
    endfunction

endpackage

[rtl/rehb_if.sv]
// Channel interfaces of the Raft election and heartbeat controller.
// Input beats carry responses, ticks and client appends; output beats carry requests and status.
// Depends on rehb_pkg for field widths.
interface rehb_in_if;
    logic                              valid;
    logic                              ready;
    logic [1:0]                        mode;
    logic [rehb_pkg::PEER_W-1:0]       peer;
    logic [rehb_pkg::TERM_W-1:0]       reply_term;
    logic                              granted;

    modport source (output valid, mode, peer, reply_term, granted, input ready);
    modport sink   (input valid, mode, peer, reply_term, granted, output ready);
endinterface

interface rehb_out_if;
    logic                              valid;
    logic                              ready;
    logic [1:0]                        kind;
    logic [rehb_pkg::PEER_W-1:0]       dest_peer;
    logic [rehb_pkg::TERM_W-1:0]       term;
    logic [rehb_pkg::IDX_W-1:0]        log_index;
    logic [rehb_pkg::TERM_W-1:0]       log_term;
    logic [1:0]                        role;
    logic [1:0]                        status;
    logic                              last;

    modport source (output valid, kind, dest_peer, term, log_index, log_term, role, status,
                    last, input ready);
    modport sink   (input valid, kind, dest_peer, term, log_index, log_term, role, status,
                    last, output ready);
endinterface

[rtl/rehb_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
module rehb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/rehb_arm.sv]
// Election timer draw: election_min plus the LFSR value modulo election_span.
// Restoring remainder unit, one quotient bit per cycle. Depends on rehb_pkg.
module rehb_arm (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic [rehb_pkg::LFSR_W-1:0]       i_lfsr,
    input  logic [15:0]                       i_min,
    input  logic [15:0]                       i_span,
    output logic                              o_busy,
    output logic                              o_done,
    output logic [rehb_pkg::CD_W-1:0]         o_countdown
);

    localparam int CNT_W = $clog2(rehb_pkg::LFSR_W + 1);

    logic                         r_busy, n_busy;
    logic                         r_done, n_done;
    logic [CNT_W-1:0]             r_cnt, n_cnt;
    logic [rehb_pkg::LFSR_W-1:0]  r_dvd, n_dvd;
    logic [rehb_pkg::LFSR_W:0]    r_rem, n_rem;
    logic [15:0]                  r_span, n_span;
    logic [15:0]                  r_min, n_min;
    logic [rehb_pkg::LFSR_W:0]    rem_sh;

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_dvd  = r_dvd;
        n_rem  = r_rem;
        n_span = r_span;
        n_min  = r_min;
        rem_sh = {r_rem[rehb_pkg::LFSR_W-1:0], r_dvd[rehb_pkg::LFSR_W-1]};
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = CNT_W'(rehb_pkg::LFSR_W);
            n_dvd  = i_lfsr;
            n_rem  = '0;
            n_span = i_span;
            n_min  = i_min;
        end else if (r_busy) begin
            n_dvd = {r_dvd[rehb_pkg::LFSR_W-2:0], 1'b0};
            n_rem = (rem_sh >= {1'b0, r_span}) ? rem_sh - {1'b0, r_span} : rem_sh;
            n_cnt = r_cnt - CNT_W'(1);
            if (r_cnt == CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_dvd  <= n_dvd;
        r_rem  <= n_rem;
        r_span <= n_span;
        r_min  <= n_min;
    end

    assign o_busy      = r_busy | r_done;
    assign o_done      = r_done;
    assign o_countdown = {1'b0, r_min} +
                         ((r_span == '0) ? '0 : r_rem);

endmodule

[rtl/rehb_front.sv]
// Front end: accepts input beats, decodes the mode, checks the peer and queues commands.
// Two-entry queue toward the back end. Depends on rehb_pkg and rehb_if.
module rehb_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    rehb_in_if.sink          i_in,
    input  rehb_pkg::t_cfg   i_cfg,
    output rehb_pkg::t_cmd   o_cmd,
    output logic             o_cmd_valid,
    input  logic             i_cmd_pop
);

    rehb_pkg::t_cmd                 r_q [2];
    logic                           r_wp, r_rp;
    logic [1:0]                     r_cnt;
    rehb_pkg::t_cmd                 cmd_in;
    logic [rehb_pkg::NODE_W-1:0]    nodes;
    logic                           push, pop;

    assign nodes = rehb_pkg::node_count(i_cfg.cluster);

    always_comb begin
        unique case (i_in.mode)
            rehb_pkg::MODE_TICK:   cmd_in.op = rehb_pkg::OP_TICK;
            rehb_pkg::MODE_VOTE:   cmd_in.op = rehb_pkg::OP_VOTE;
            rehb_pkg::MODE_APPEND: cmd_in.op = rehb_pkg::OP_APPEND;
            default:               cmd_in.op = rehb_pkg::OP_CLIENT;
        endcase
        cmd_in.peer       = i_in.peer;
        cmd_in.peer_ok    = ({1'b0, i_in.peer} < nodes) && (i_in.peer != i_cfg.self_idx);
        cmd_in.reply_term = i_in.reply_term;
        cmd_in.granted    = i_in.granted;
    end

    assign i_in.ready  = (r_cnt != 2'd2);
    assign push        = i_in.valid && i_in.ready;
    assign pop         = i_cmd_pop && (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rp];
    assign o_cmd_valid = (r_cnt != 2'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
        if (push) begin
            r_q[r_wp] <= cmd_in;
        end
    end

endmodule

[rtl/rehb_back.sv]
// Back end: node role state, election and heartbeat sequencing, result output register.
// Uses rehb_arm for timer draws and rehb_ram for entry terms. Depends on rehb_pkg, rehb_if.
module rehb_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  rehb_pkg::t_cfg   i_cfg,
    input  rehb_pkg::t_cmd   i_cmd,
    input  logic             i_cmd_valid,
    output logic             o_cmd_pop,
    rehb_out_if.source       o_out
);

    localparam int NW = rehb_pkg::NODE_W;
    localparam int PW = rehb_pkg::PEER_W;
    localparam int IW = rehb_pkg::IDX_W;
    localparam int TW = rehb_pkg::TERM_W;

    rehb_pkg::t_state              r_state, n_state;
    logic [1:0]                    r_role, n_role;
    logic [TW-1:0]                 r_term, n_term;
    logic [3:0]                    r_votes, n_votes;
    logic [rehb_pkg::MAX_NODES-1:0] r_mask, n_mask;
    logic [rehb_pkg::CD_W-1:0]     r_cd, n_cd;
    logic [15:0]                   r_hb, n_hb;
    logic [rehb_pkg::LFSR_W-1:0]   r_lfsr, n_lfsr;
    logic                          r_arm_go, n_arm_go;
    logic [IW-1:0]                 r_log, n_log;
    logic [IW-1:0]                 r_next [rehb_pkg::MAX_NODES];
    logic [IW-1:0]                 n_next [rehb_pkg::MAX_NODES];
    logic [NW-1:0]                 r_i, n_i;

    logic [1:0]                    r_cur_kind, n_cur_kind;
    logic [PW-1:0]                 r_cur_dest, n_cur_dest;
    logic [IW-1:0]                 r_cur_idx, n_cur_idx;
    logic [1:0]                    r_cur_status, n_cur_status;
    logic                          r_cur_last, n_cur_last;
    logic                          r_cur_direct, n_cur_direct;

    logic                          r_ov, n_ov;
    logic [1:0]                    r_o_kind, n_o_kind;
    logic [PW-1:0]                 r_o_dest, n_o_dest;
    logic [TW-1:0]                 r_o_term, n_o_term;
    logic [IW-1:0]                 r_o_idx, n_o_idx;
    logic [TW-1:0]                 r_o_lterm, n_o_lterm;
    logic [1:0]                    r_o_role, n_o_role;
    logic [1:0]                    r_o_status, n_o_status;
    logic                          r_o_last, n_o_last;

    logic [NW-1:0]                 nodes, half, last_i;
    logic [PW-1:0]                 nx_sel;
    logic [IW-1:0]                 nx_val;
    logic                          arm_busy, arm_done;
    logic [rehb_pkg::CD_W-1:0]     arm_cd;
    logic                          ram_we, ram_re;
    logic [rehb_pkg::LOG_AW-1:0]   ram_raddr;
    logic [TW-1:0]                 ram_rdata;
    logic                          lead, arm_req, next_dec;
    logic [rehb_pkg::CD_W-1:0]     cd_dec;
    logic [15:0]                   hb_inc;
    logic [3:0]                    votes_inc;
    logic [IW-1:0]                 rd_idx;

    assign nodes  = rehb_pkg::node_count(i_cfg.cluster);
    assign half   = nodes >> 1;
    assign last_i = ({1'b0, i_cfg.self_idx} == nodes - NW'(1)) ? nodes - NW'(2)
                                                                 : nodes - NW'(1);
    assign nx_sel = (r_state == rehb_pkg::ST_PEER) ? r_i[PW-1:0] : i_cmd.peer;
    assign nx_val = r_next[nx_sel];

    rehb_arm u_arm (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (r_arm_go),
        .i_lfsr      (r_lfsr),
        .i_min       (i_cfg.elec_min),
        .i_span      (i_cfg.elec_span),
        .o_busy      (arm_busy),
        .o_done      (arm_done),
        .o_countdown (arm_cd)
    );

    rehb_ram #(
        .WIDTH (rehb_pkg::TERM_W),
        .DEPTH (rehb_pkg::LOG_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_log[rehb_pkg::LOG_AW-1:0]),
        .i_wdata (r_term),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_state      = r_state;
        n_role       = r_role;
        n_term       = r_term;
        n_votes      = r_votes;
        n_mask       = r_mask;
        n_cd         = r_cd;
        n_hb         = r_hb;
        n_lfsr       = r_lfsr;
        n_arm_go     = 1'b0;
        n_log        = r_log;
        n_next       = r_next;
        n_i          = r_i;
        n_cur_kind   = r_cur_kind;
        n_cur_dest   = r_cur_dest;
        n_cur_idx    = r_cur_idx;
        n_cur_status = r_cur_status;
        n_cur_last   = r_cur_last;
        n_cur_direct = r_cur_direct;
        n_ov         = r_ov && !o_out.ready;
        n_o_kind     = r_o_kind;
        n_o_dest     = r_o_dest;
        n_o_term     = r_o_term;
        n_o_idx      = r_o_idx;
        n_o_lterm    = r_o_lterm;
        n_o_role     = r_o_role;
        n_o_status   = r_o_status;
        n_o_last     = r_o_last;
        o_cmd_pop    = 1'b0;
        ram_we       = 1'b0;
        ram_re       = 1'b0;
        rd_idx       = '0;
        lead         = 1'b0;
        arm_req      = 1'b0;
        next_dec     = 1'b0;
        cd_dec       = (r_cd != '0) ? r_cd - rehb_pkg::CD_W'(1) : '0;
        hb_inc       = (r_hb != rehb_pkg::HB_SAT) ? r_hb + 16'd1 : r_hb;
        votes_inc    = (r_votes != rehb_pkg::VOTES_SAT) ? r_votes + 4'd1 : r_votes;

        if (arm_done) begin
            n_cd = arm_cd;
        end

        unique case (r_state)
            rehb_pkg::ST_IDLE: begin
                if (i_cmd_valid && !r_arm_go && !arm_busy) begin
                    o_cmd_pop = 1'b1;
                    unique case (i_cmd.op)
                        rehb_pkg::OP_TICK: begin
                            n_i = '0;
                            if (r_role != rehb_pkg::ROLE_LEADER) begin
                                n_cd = cd_dec;
                                if (cd_dec == '0) begin
                                    n_term     = (r_term != rehb_pkg::TERM_MAX) ?
                                                 r_term + TW'(1) : r_term;
                                    n_votes    = 4'd1;
                                    n_mask     = '0;
                                    arm_req    = 1'b1;
                                    n_role     = rehb_pkg::ROLE_CANDIDATE;
                                    lead       = (4'd1 > half);
                                    n_cur_kind = rehb_pkg::KIND_VREQ;
                                    n_cur_idx  = r_log;
                                    n_state    = rehb_pkg::ST_PEER;
                                end
                            end else if (hb_inc >= i_cfg.hb_interval) begin
                                n_hb       = '0;
                                n_cur_kind = rehb_pkg::KIND_HBEAT;
                                n_state    = rehb_pkg::ST_PEER;
                            end else begin
                                n_hb = hb_inc;
                            end
                        end
                        rehb_pkg::OP_VOTE: begin
                            if (i_cmd.peer_ok) begin
                                if (i_cmd.reply_term > r_term) begin
                                    n_term  = i_cmd.reply_term;
                                    n_role  = rehb_pkg::ROLE_FOLLOWER;
                                    n_votes = '0;
                                    n_mask  = '0;
                                    arm_req = 1'b1;
                                end else if (i_cmd.reply_term == r_term &&
                                             r_role == rehb_pkg::ROLE_CANDIDATE &&
                                             i_cmd.granted && !r_mask[i_cmd.peer]) begin
                                    n_mask[i_cmd.peer] = 1'b1;
                                    n_votes            = votes_inc;
                                    lead               = (votes_inc > half);
                                end
                            end
                        end
                        rehb_pkg::OP_APPEND: begin
                            if (i_cmd.peer_ok) begin
                                if (i_cmd.reply_term > r_term) begin
                                    n_term  = i_cmd.reply_term;
                                    n_role  = rehb_pkg::ROLE_FOLLOWER;
                                    n_votes = '0;
                                    n_mask  = '0;
                                    arm_req = 1'b1;
                                end else if (i_cmd.reply_term == r_term &&
                                             r_role == rehb_pkg::ROLE_LEADER &&
                                             !i_cmd.granted && nx_val > IW'(1)) begin
                                    next_dec = 1'b1;
                                end
                            end
                        end
                        default: begin
                            n_cur_kind   = rehb_pkg::KIND_STATUS;
                            n_cur_dest   = '0;
                            n_cur_last   = 1'b1;
                            n_cur_direct = 1'b0;
                            n_state      = rehb_pkg::ST_EMIT;
                            if (r_role != rehb_pkg::ROLE_LEADER) begin
                                n_cur_status = rehb_pkg::STAT_NOT_LEADER;
                            end else if (r_log >= IW'(rehb_pkg::LOG_DEPTH)) begin
                                n_cur_status = rehb_pkg::STAT_FULL;
                            end else begin
                                n_cur_status = rehb_pkg::STAT_OK;
                                n_cur_direct = 1'b1;
                                ram_we       = 1'b1;
                                n_log        = r_log + IW'(1);
                            end
                            n_cur_idx = n_log;
                            rd_idx    = r_log;
                            ram_re    = !n_cur_direct;
                        end
                    endcase
                end
            end
            rehb_pkg::ST_PEER: begin
                if (r_i >= nodes) begin
                    n_state = rehb_pkg::ST_IDLE;
                end else if (r_i[PW-1:0] == i_cfg.self_idx) begin
                    n_i = r_i + NW'(1);
                end else begin
                    rd_idx       = (r_cur_kind == rehb_pkg::KIND_VREQ) ? r_cur_idx
                                                                       : nx_val - IW'(1);
                    n_cur_idx    = rd_idx;
                    ram_re       = 1'b1;
                    n_cur_dest   = r_i[PW-1:0];
                    n_cur_last   = (r_i == last_i);
                    n_cur_status = rehb_pkg::STAT_OK;
                    n_cur_direct = 1'b0;
                    n_state      = rehb_pkg::ST_EMIT;
                end
            end
            rehb_pkg::ST_EMIT: begin
                if (!r_ov || o_out.ready) begin
                    n_ov       = 1'b1;
                    n_o_kind   = r_cur_kind;
                    n_o_dest   = r_cur_dest;
                    n_o_term   = r_term;
                    n_o_idx    = r_cur_idx;
                    n_o_lterm  = r_cur_direct ? r_term :
                                 ((r_cur_idx == '0) ? '0 : ram_rdata);
                    n_o_role   = r_role;
                    n_o_status = r_cur_status;
                    n_o_last   = r_cur_last;
                    if (r_cur_last) begin
                        n_state = rehb_pkg::ST_IDLE;
                    end else begin
                        n_i     = r_i + NW'(1);
                        n_state = rehb_pkg::ST_PEER;
                    end
                end
            end
            default: begin
                n_state = rehb_pkg::ST_IDLE;
            end
        endcase

        ram_raddr = rehb_pkg::LOG_AW'(rd_idx - IW'(1));

        if (arm_req) begin
            n_lfsr   = rehb_pkg::lfsr_step(r_lfsr);
            n_arm_go = 1'b1;
        end
        if (lead) begin
            n_role = rehb_pkg::ROLE_LEADER;
            n_hb   = rehb_pkg::HB_SAT;
            for (int k = 0; k < rehb_pkg::MAX_NODES; k++) begin
                n_next[k] = r_log + IW'(1);
            end
        end else if (next_dec) begin
            n_next[nx_sel] = nx_val - IW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= rehb_pkg::ST_IDLE;
            r_role   <= rehb_pkg::ROLE_FOLLOWER;
            r_term   <= '0;
            r_votes  <= '0;
            r_mask   <= '0;
            r_cd     <= '0;
            r_hb     <= '0;
            r_lfsr   <= rehb_pkg::lfsr_step(rehb_pkg::LFSR_SEED);
            r_arm_go <= 1'b1;
            r_log    <= '0;
            r_i      <= '0;
            r_ov     <= 1'b0;
            for (int k = 0; k < rehb_pkg::MAX_NODES; k++) begin
                r_next[k] <= IW'(1);
            end
        end else begin
            r_state  <= n_state;
            r_role   <= n_role;
            r_term   <= n_term;
            r_votes  <= n_votes;
            r_mask   <= n_mask;
            r_cd     <= n_cd;
            r_hb     <= n_hb;
            r_lfsr   <= n_lfsr;
            r_arm_go <= n_arm_go;
            r_log    <= n_log;
            r_i      <= n_i;
            r_ov     <= n_ov;
            r_next   <= n_next;
        end
        r_cur_kind   <= n_cur_kind;
        r_cur_dest   <= n_cur_dest;
        r_cur_idx    <= n_cur_idx;
        r_cur_status <= n_cur_status;
        r_cur_last   <= n_cur_last;
        r_cur_direct <= n_cur_direct;
        r_o_kind     <= n_o_kind;
        r_o_dest     <= n_o_dest;
        r_o_term     <= n_o_term;
        r_o_idx      <= n_o_idx;
        r_o_lterm    <= n_o_lterm;
        r_o_role     <= n_o_role;
        r_o_status   <= n_o_status;
        r_o_last     <= n_o_last;
    end

    assign o_out.valid     = r_ov;
    assign o_out.kind      = r_o_kind;
    assign o_out.dest_peer = r_o_dest;
    assign o_out.term      = r_o_term;
    assign o_out.log_index = r_o_idx;
    assign o_out.log_term  = r_o_lterm;
    assign o_out.role      = r_o_role;
    assign o_out.status    = r_o_status;
    assign o_out.last      = r_o_last;

endmodule

[rtl/raft_election_heartbeat_top.sv]
// Top level of the Raft election and heartbeat controller: configuration registers,
// front end, back end and checks. Depends on rehb_pkg, rehb_if, rehb_front, rehb_back.
//
//   channel  direction  handshake              beat contents
//   i_in     in         valid/ready            mode, peer, reply_term, granted
//   o_out    out        valid/ready            kind, dest_peer, term, log_index,
//                                              log_term, role, status, last
//   apb      in         psel/penable/pready    paddr, pwdata, prdata
//
// A response beat leaves the head of the two-entry queue once the back end is idle.
// A tick that fans out visits each peer slot in a peer state and an emit state (the self
// slot is skipped in the peer state); a client append goes straight to the emit state.
// Each timer draw runs the 16-step remainder unit, and the next beat waits for it.
// After reset the first draw runs the same way; beats are queued meanwhile.
// Output stalls hold the sequencer; the queue keeps accepting until it is full.
module raft_election_heartbeat_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    rehb_in_if.sink                       i_in,
    rehb_out_if.source                    o_out,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [rehb_pkg::CFG_AW-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    rehb_pkg::t_cfg  r_cfg;
    rehb_pkg::t_cmd  cmd;
    logic            cmd_valid;
    logic            cmd_pop;
    logic [2:0]      reg_sel;

    assign pready  = 1'b1;
    assign reg_sel = paddr[rehb_pkg::CFG_AW-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.cluster     <= rehb_pkg::RST_CLUSTER;
            r_cfg.self_idx    <= rehb_pkg::RST_SELF;
            r_cfg.hb_interval <= rehb_pkg::RST_HB;
            r_cfg.elec_min    <= rehb_pkg::RST_EMIN;
            r_cfg.elec_span   <= rehb_pkg::RST_ESPAN;
        end else if (psel && penable && pwrite) begin
            unique case (reg_sel)
                rehb_pkg::REG_CLUSTER: r_cfg.cluster     <= pwdata[rehb_pkg::NODE_W-1:0];
                rehb_pkg::REG_SELF:    r_cfg.self_idx    <= pwdata[rehb_pkg::PEER_W-1:0];
                rehb_pkg::REG_HB:      r_cfg.hb_interval <= pwdata[15:0];
                rehb_pkg::REG_EMIN:    r_cfg.elec_min    <= pwdata[15:0];
                rehb_pkg::REG_ESPAN:   r_cfg.elec_span   <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_sel)
            rehb_pkg::REG_CLUSTER: prdata = 32'(r_cfg.cluster);
            rehb_pkg::REG_SELF:    prdata = 32'(r_cfg.self_idx);
            rehb_pkg::REG_HB:      prdata = 32'(r_cfg.hb_interval);
            rehb_pkg::REG_EMIN:    prdata = 32'(r_cfg.elec_min);
            rehb_pkg::REG_ESPAN:   prdata = 32'(r_cfg.elec_span);
            default:               prdata = '0;
        endcase
    end

    rehb_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_cfg       (r_cfg),
        .o_cmd       (cmd),
        .o_cmd_valid (cmd_valid),
        .i_cmd_pop   (cmd_pop)
    );

    rehb_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cmd       (cmd),
        .i_cmd_valid (cmd_valid),
        .o_cmd_pop   (cmd_pop),
        .o_out       (o_out)
    );

    a_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.kind == rehb_pkg::KIND_STATUS) |-> o_out.last)
        else $error("status beat without last");

    a_zero_index_term: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.log_index == '0) |-> (o_out.log_term == '0))
        else $error("nonzero log term at index zero");

    a_hbeat_leader: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.kind == rehb_pkg::KIND_HBEAT) |->
        (o_out.role == rehb_pkg::ROLE_LEADER))
        else $error("heartbeat from a non-leader");

    a_request_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.kind != rehb_pkg::KIND_STATUS) |->
        (o_out.status == rehb_pkg::STAT_OK))
        else $error("request beat carries a status");

endmodule

[test/tb.sv]
// Testbench for the Raft election and heartbeat controller top level.
// Drives ticks, vote and append replies and client appends, predicts every output beat
// and checks it in order. Depends on rehb_pkg, rehb_if and raft_election_heartbeat_top.
`timescale 1ns / 1ps

module tb;

    localparam int CYCLE_LIMIT = 1500000;
    localparam int SETTLE_CYCLES = 80;

    typedef struct {
        logic [1:0]  kind;
        logic [2:0]  dest_peer;
        logic [31:0] term;
        logic [10:0] log_index;
        logic [31:0] log_term;
        logic [1:0]  role;
        logic [1:0]  status;
        logic        last;
    } t_beat;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [rehb_pkg::CFG_AW-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    rehb_in_if  in_ch ();
    rehb_out_if out_ch ();

    raft_election_heartbeat_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Shadow configuration and node state.
    logic [3:0]  cfg_cluster;
    logic [2:0]  cfg_self;
    logic [15:0] cfg_hb;
    logic [15:0] cfg_emin;
    logic [15:0] cfg_espan;

    logic [1:0]  node_role;
    logic [31:0] node_term;
    logic [3:0]  votes;
    logic [7:0]  voted_mask;
    logic [16:0] countdown;
    logic [15:0] hb_elapsed;
    logic [15:0] rng;
    int          log_len;
    logic [31:0] log_terms [rehb_pkg::LOG_DEPTH];
    int          next_idx [rehb_pkg::MAX_NODES];
    int          match_idx [rehb_pkg::MAX_NODES];

    t_beat expected_beats [$];
    int    errors;
    int    beats_checked;
    int    items_sent;
    int    cycles;
    bit    no_idle;
    bit    hold_req;
    int    hold_left;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    function automatic int nodes();
        if (cfg_cluster == 4'd0) return 1;
        if (cfg_cluster > 4'(rehb_pkg::MAX_NODES)) return rehb_pkg::MAX_NODES;
        return int'(cfg_cluster);
    endfunction

    function automatic logic [31:0] entry_term(input int idx);
        if (idx == 0 || idx > rehb_pkg::LOG_DEPTH) return 32'd0;
        return log_terms[idx-1];
    endfunction

    function automatic bit valid_peer(input int p);
        return p < nodes() && p != int'(cfg_self);
    endfunction

    task automatic rearm_timeout();
        logic fb;
        fb = rng[0] ^ rng[2] ^ rng[3] ^ rng[5];
        rng = {fb, rng[15:1]};
        countdown = {1'b0, cfg_emin} + ((cfg_espan != 0) ? 17'(rng % cfg_espan) : 17'd0);
    endtask

    task automatic take_leadership();
        node_role = rehb_pkg::ROLE_LEADER;
        for (int i = 0; i < rehb_pkg::MAX_NODES; i++) begin
            next_idx[i] = log_len + 1;
            match_idx[i] = 0;
        end
        hb_elapsed = rehb_pkg::HB_SAT;
    endtask

    task automatic model_reset();
        cfg_cluster = rehb_pkg::RST_CLUSTER;
        cfg_self    = rehb_pkg::RST_SELF;
        cfg_hb      = rehb_pkg::RST_HB;
        cfg_emin    = rehb_pkg::RST_EMIN;
        cfg_espan   = rehb_pkg::RST_ESPAN;
        node_role   = rehb_pkg::ROLE_FOLLOWER;
        node_term   = '0;
        votes       = '0;
        voted_mask  = '0;
        hb_elapsed  = '0;
        rng         = rehb_pkg::LFSR_SEED;
        log_len     = 0;
        for (int i = 0; i < rehb_pkg::LOG_DEPTH; i++) log_terms[i] = '0;
        for (int i = 0; i < rehb_pkg::MAX_NODES; i++) begin
            next_idx[i] = 1;
            match_idx[i] = 0;
        end
        rearm_timeout();
    endtask

    task automatic model_step(input logic [1:0] md, input logic [2:0] pr,
                              input logic [31:0] rt, input logic g);
        t_beat step_beats [$];
        t_beat b;
        int    n;
        int    prev;
        n = nodes();
        b.status = rehb_pkg::STAT_OK;
        if (md == rehb_pkg::MODE_TICK) begin
            if (node_role != rehb_pkg::ROLE_LEADER) begin
                if (countdown > 0) countdown--;
                if (countdown == 0) begin
                    node_role = rehb_pkg::ROLE_CANDIDATE;
                    if (node_term != rehb_pkg::TERM_MAX) node_term++;
                    votes = 4'd1;
                    voted_mask = '0;
                    rearm_timeout();
                    for (int i = 0; i < n; i++) begin
                        if (i != int'(cfg_self)) begin
                            b.kind = rehb_pkg::KIND_VREQ;
                            b.dest_peer = 3'(i);
                            b.term = node_term;
                            b.log_index = 11'(log_len);
                            b.log_term = entry_term(log_len);
                            step_beats.push_back(b);
                        end
                    end
                    if (int'(votes) > n / 2) take_leadership();
                end
            end else begin
                if (hb_elapsed < rehb_pkg::HB_SAT) hb_elapsed++;
                if (hb_elapsed >= cfg_hb) begin
                    hb_elapsed = '0;
                    for (int i = 0; i < n; i++) begin
                        if (i != int'(cfg_self)) begin
                            prev = (next_idx[i] != 0) ? next_idx[i] - 1 : 0;
                            b.kind = rehb_pkg::KIND_HBEAT;
                            b.dest_peer = 3'(i);
                            b.term = node_term;
                            b.log_index = 11'(prev);
                            b.log_term = entry_term(prev);
                            step_beats.push_back(b);
                        end
                    end
                end
            end
        end else if (md == rehb_pkg::MODE_VOTE || md == rehb_pkg::MODE_APPEND) begin
            if (valid_peer(int'(pr))) begin
                if (rt > node_term) begin
                    node_term = rt;
                    node_role = rehb_pkg::ROLE_FOLLOWER;
                    votes = '0;
                    voted_mask = '0;
                    rearm_timeout();
                end else if (rt == node_term) begin
                    if (md == rehb_pkg::MODE_VOTE) begin
                        if (node_role == rehb_pkg::ROLE_CANDIDATE && g && !voted_mask[pr]) begin
                            voted_mask[pr] = 1'b1;
                            if (votes < rehb_pkg::VOTES_SAT) votes++;
                            if (int'(votes) > n / 2) take_leadership();
                        end
                    end else if (node_role == rehb_pkg::ROLE_LEADER) begin
                        if (g) begin
                            match_idx[pr] = (next_idx[pr] != 0) ? next_idx[pr] - 1 : 0;
                            next_idx[pr] = match_idx[pr] + 1;
                        end else if (next_idx[pr] > 1) begin
                            next_idx[pr]--;
                        end
                    end
                end
            end
        end else begin
            if (node_role != rehb_pkg::ROLE_LEADER) begin
                b.status = rehb_pkg::STAT_NOT_LEADER;
            end else if (log_len >= rehb_pkg::LOG_DEPTH) begin
                b.status = rehb_pkg::STAT_FULL;
            end else begin
                log_terms[log_len] = node_term;
                log_len++;
                b.status = rehb_pkg::STAT_OK;
            end
            b.kind = rehb_pkg::KIND_STATUS;
            b.dest_peer = '0;
            b.term = node_term;
            b.log_index = 11'(log_len);
            b.log_term = entry_term(log_len);
            step_beats.push_back(b);
        end
        foreach (step_beats[j]) begin
            step_beats[j].role = node_role;
            step_beats[j].last = (j == step_beats.size() - 1);
            expected_beats.push_back(step_beats[j]);
        end
    endtask

    // Sender: fields change only at rising edges, ready is sampled at the falling edge.
    task automatic send_item(input logic [1:0] md, input logic [2:0] pr,
                             input logic [31:0] rt, input logic g);
        int  gap;
        bit  rdy;
        gap = 0;
        if (!no_idle && $urandom_range(99) < 35) gap = $urandom_range(1, 4);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.mode       <= md;
        in_ch.peer       <= pr;
        in_ch.reply_term <= rt;
        in_ch.granted    <= g;
        do begin
            @(negedge i_clk);
            rdy = in_ch.ready;
            @(posedge i_clk);
        end while (!rdy);
        items_sent++;
        model_step(md, pr, rt, g);
    endtask

    task automatic release_input();
        in_ch.valid <= 1'b0;
    endtask

    task automatic drain();
        release_input();
        while (expected_beats.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
        drain();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= rehb_pkg::CFG_AW'({idx, 2'b00});
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            rehb_pkg::REG_CLUSTER: cfg_cluster = value[3:0];
            rehb_pkg::REG_SELF:    cfg_self    = value[2:0];
            rehb_pkg::REG_HB:      cfg_hb      = value[15:0];
            rehb_pkg::REG_EMIN:    cfg_emin    = value[15:0];
            rehb_pkg::REG_ESPAN:   cfg_espan   = value[15:0];
            default: ;
        endcase
    endtask

    task automatic configure(input logic [3:0] cl, input logic [2:0] sf, input logic [15:0] hb,
                             input logic [15:0] emin, input logic [15:0] espan);
        write_reg(rehb_pkg::REG_CLUSTER, 32'(cl));
        write_reg(rehb_pkg::REG_SELF, 32'(sf));
        write_reg(rehb_pkg::REG_HB, 32'(hb));
        write_reg(rehb_pkg::REG_EMIN, 32'(emin));
        write_reg(rehb_pkg::REG_ESPAN, 32'(espan));
    endtask

    function automatic int some_peer();
        for (int i = 0; i < nodes(); i++) if (i != int'(cfg_self)) return i;
        return -1;
    endfunction

    // A higher term from a real peer forces follower and draws a fresh timeout.
    task automatic demote();
        int p;
        p = some_peer();
        if (p >= 0) send_item(rehb_pkg::MODE_APPEND, 3'(p), node_term + 1, 1'b1);
    endtask

    task automatic win_election();
        if (node_role == rehb_pkg::ROLE_LEADER) demote();
        while (node_role == rehb_pkg::ROLE_FOLLOWER)
            send_item(rehb_pkg::MODE_TICK, '0, '0, 1'b0);
        for (int i = 0; i < nodes() && node_role == rehb_pkg::ROLE_CANDIDATE; i++) begin
            if (i != int'(cfg_self)) send_item(rehb_pkg::MODE_VOTE, 3'(i), node_term, 1'b1);
        end
    endtask

    task automatic test_reset_defaults();
        send_item(rehb_pkg::MODE_CLIENT, '0, '0, 1'b0);
        while (node_role != rehb_pkg::ROLE_LEADER) send_item(rehb_pkg::MODE_TICK, '0, '0, 1'b0);
        send_item(rehb_pkg::MODE_CLIENT, '0, '0, 1'b0);
        send_item(rehb_pkg::MODE_TICK, '0, '0, 1'b0);
        drain();
    endtask

    task automatic test_election();
        configure(4'd5, 3'd2, 16'd2, 16'd3, 16'd4);
        demote();
        while (node_role == rehb_pkg::ROLE_FOLLOWER) send_item(rehb_pkg::MODE_TICK, '0, '0, 1'b0);
        send_item(rehb_pkg::MODE_VOTE, 3'd2, node_term, 1'b1);
        send_item(rehb_pkg::MODE_VOTE, 3'd6, node_term, 1'b1);
        send_item(rehb_pkg::MODE_VOTE, 3'd0, node_term - 1, 1'b1);
        send_item(rehb_pkg::MODE_VOTE, 3'd0, node_term, 1'b0);
        send_item(rehb_pkg::MODE_VOTE, 3'd1, node_term, 1'b1);
        send_item(rehb_pkg::MODE_VOTE, 3'd1, node_term, 1'b1);
        send_item(rehb_pkg::MODE_VOTE, 3'd4, node_term, 1'b1);
        send_item(rehb_pkg::MODE_CLIENT, '0, '0, 1'b0);
        send_item(rehb_pkg::MODE_APPEND, 3'd0, node_term, 1'b1);
        send_item(rehb_pkg::MODE_APPEND, 3'd1, node_term, 1'b0);
        send_item(rehb_pkg::MODE_APPEND, 3'd3, node_term, 1'b0);
        repeat (4) send_item(rehb_pkg::MODE_TICK, '0, '0, 1'b0);
        send_item(rehb_pkg::MODE_VOTE, 3'd3, node_term + 1, 1'b0);
        drain();
    endtask

    task automatic test_extremes();
        configure(4'd15, 3'd7, 16'd0, 16'd0, 16'd0);
        win_election();
        repeat (2) send_item(rehb_pkg::MODE_TICK, '0, '0, 1'b0);
        configure(4'd0, 3'd7, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_item(rehb_pkg::MODE_TICK, '0, '0, 1'b0);
        configure(4'd8, 3'd7, 16'd1, 16'd1, 16'd1);
        send_item(rehb_pkg::MODE_APPEND, 3'd0, 32'hFFFF_FFFF, 1'b1);
        while (node_role == rehb_pkg::ROLE_FOLLOWER) send_item(rehb_pkg::MODE_TICK, '0, '0, 1'b0);
        repeat (3) send_item(rehb_pkg::MODE_TICK, '0, '0, 1'b0);
        configure(4'd1, 3'd0, 16'd1, 16'd1, 16'd2);
        win_election();
        drain();
    endtask

    task automatic random_item();
        int          r;
        int          p;
        logic [31:0] t;
        r = $urandom_range(99);
        p = $urandom_range(nodes() - 1);
        if (r < 15) begin
            case ($urandom_range(3))
                0: t = node_term + 1;
                1: t = node_term - 1;
                2: t = ($urandom_range(9) == 0) ? $urandom : node_term;
                default: t = node_term;
            endcase
            send_item(2'($urandom), 3'($urandom), t, 1'($urandom));
        end else if (node_role == rehb_pkg::ROLE_CANDIDATE && r < 75) begin
            send_item(rehb_pkg::MODE_VOTE, 3'(p), node_term, ($urandom_range(4) != 0));
        end else if (node_role == rehb_pkg::ROLE_LEADER && r < 45) begin
            send_item(rehb_pkg::MODE_APPEND, 3'(p), node_term, 1'($urandom));
        end else if (r < 90) begin
            send_item(rehb_pkg::MODE_TICK, '0, '0, 1'b0);
        end else begin
            send_item(rehb_pkg::MODE_CLIENT, 3'($urandom), $urandom, 1'($urandom));
        end
    endtask

    task automatic test_random();
        for (int ph = 0; ph < 6; ph++) begin
            configure((ph == 0) ? 4'd0 : 4'($urandom_range(2, 9)), 3'($urandom),
                      16'($urandom_range(0, 5)), 16'($urandom_range(0, 6)),
                      16'($urandom_range(0, 5)));
            demote();
            no_idle = (ph == 3);
            repeat ((ph == 3) ? 50 : 24) random_item();
            no_idle = 1'b0;
        end
        drain();
    endtask

    task automatic test_client_appends();
        configure(4'd1, 3'd0, 16'd3, 16'd2, 16'd3);
        win_election();
        while (node_role != rehb_pkg::ROLE_LEADER) send_item(rehb_pkg::MODE_TICK, '0, '0, 1'b0);
        repeat (12) send_item(rehb_pkg::MODE_CLIENT, '0, '0, 1'b0);
        drain();
    endtask

    task automatic test_backpressure();
        configure(4'd8, 3'd3, 16'd0, 16'd2, 16'd3);
        win_election();
        drain();
        hold_req = 1'b1;
        repeat (30) send_item(rehb_pkg::MODE_TICK, '0, '0, 1'b0);
        drain();
    endtask

    // Output side: ready changes at rising edges, beats are taken at the falling edge.
    always @(posedge i_clk) begin
        if (hold_req) begin
            hold_left = 300;
            hold_req = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= no_idle || ($urandom_range(99) >= 35);
        end
    end

    always @(negedge i_clk) begin
        t_beat e;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (expected_beats.size() == 0) begin
                errors++;
                $display("%0t: expected no beat, actual kind=%0d dest=%0d term=%0h", $time,
                         out_ch.kind, out_ch.dest_peer, out_ch.term);
            end else begin
                e = expected_beats.pop_front();
                beats_checked++;
                if (out_ch.kind !== e.kind || out_ch.dest_peer !== e.dest_peer ||
                    out_ch.term !== e.term || out_ch.log_index !== e.log_index ||
                    out_ch.log_term !== e.log_term || out_ch.role !== e.role ||
                    out_ch.status !== e.status || out_ch.last !== e.last) begin
                    errors++;
                    $display("%0t: expected k=%0d d=%0d t=%0h i=%0d lt=%0h r=%0d s=%0d l=%0d",
                             $time, e.kind, e.dest_peer, e.term, e.log_index, e.log_term,
                             e.role, e.status, e.last);
                    $display("%0t: actual   k=%0d d=%0d t=%0h i=%0d lt=%0h r=%0d s=%0d l=%0d",
                             $time, out_ch.kind, out_ch.dest_peer, out_ch.term,
                             out_ch.log_index, out_ch.log_term, out_ch.role, out_ch.status,
                             out_ch.last);
                end
            end
        end
    end

    initial begin
        i_rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_ch.valid = 1'b0;
        in_ch.mode = rehb_pkg::MODE_TICK;
        in_ch.peer = '0;
        in_ch.reply_term = '0;
        in_ch.granted = 1'b0;
        out_ch.ready = 1'b0;
        errors = 0;
        beats_checked = 0;
        items_sent = 0;
        cycles = 0;
        no_idle = 1'b0;
        hold_req = 1'b0;
        hold_left = 0;
        model_reset();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_election();
        test_extremes();
        test_random();
        test_client_appends();
        test_backpressure();

        drain();
        $display("Sent %0d items and checked %0d output beats over %0d cycles,", items_sent,
                 beats_checked, cycles);
        $display("covering elections, heartbeats, stale and bad replies, appends and stalls.");
        if (errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

[raft_election_heartbeat_top.f]
rtl/rehb_pkg.sv
rtl/rehb_if.sv
rtl/rehb_ram.sv
rtl/rehb_arm.sv
rtl/rehb_front.sv
rtl/rehb_back.sv
rtl/raft_election_heartbeat_top.sv
test/tb.sv
